@@ hdl/rms_norm_backward_row_macros.svh @@
// assertion macros for the rms norm backward row block
// used by the top level; expects clk and arst_n in scope
`ifndef RMS_NORM_BACKWARD_ROW_MACROS_SVH
`define RMS_NORM_BACKWARD_ROW_MACROS_SVH

// same-cycle implication, disabled during reset
`define RMSNB_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define RMSNB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/rmsnb_pkg.sv @@
// shared types, widths and constants of the rms norm backward row block
// no dependencies
package rmsnb_pkg;

	localparam int MAX_ROW_DEF = 64;
	localparam int LEN_W       = 7;
	localparam int EPS_W       = 32;
	localparam int DATA_W      = 16;
	localparam int SUM_W       = 37;
	// signed dot product needs one more bit: a full row of -8.0 * -8.0 reaches +2^36
	localparam int DOT_W       = SUM_W + 1;
	localparam int MS_W        = 33;
	localparam int ROWDEN_W    = LEN_W + MS_W;
	localparam int INV_W       = 31;
	localparam int COEF_W      = 49;
	localparam int CM_W        = 48;
	localparam int CFG_IDX_W   = 1;
	localparam int DIV_W       = 64;
	localparam int DEN_W       = 42;
	localparam int ROOT_W      = 64;
	localparam int GM_W        = 62;
	localparam int PROD_W      = GM_W + INV_W;
	localparam int STEP_W      = 7;
	localparam int DIV_STEPS   = 64;
	localparam int ROOT_STEPS  = 32;
	localparam int MUL_STEPS   = INV_W;
	localparam int ROW_LEN_RST = 64;
	localparam int EPS_RST     = 168;

	localparam logic [DIV_W-1:0]  Q_NUM      = 64'h4000_0000_0000_0000;
	localparam logic [ROOT_W-1:0] ROOT_B0    = 64'h4000_0000_0000_0000;
	localparam logic [CM_W-1:0]   COEF_LIMIT = 48'h8000_0000_0000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROW_LENGTH = 1'b0,
		REG_EPSILON    = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		CS_IDLE,
		CS_MS,
		CS_Q,
		CS_ROOT,
		CS_GM,
		CS_MUL,
		CS_FIN,
		CS_OUT
	} coef_state_t;

	// finished row handed from front to coefficient unit
	typedef struct packed {
		logic [LEN_W-1:0]        len;
		logic [LEN_W-1:0]        n;
		logic [SUM_W-1:0]        sq;
		logic signed [DOT_W-1:0] dot;
	} row_job_t;

	// per-row scale factors handed to the emitter
	typedef struct packed {
		logic [LEN_W-1:0]         n;
		logic [INV_W-1:0]         inv;
		logic signed [COEF_W-1:0] coef;
	} row_coef_t;

endpackage

@@ hdl/rmsnb_if.sv @@
// valid/ready channels of the rms norm backward row block
// depends on nothing but the handshake convention
interface rmsnb_pair_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] grad_out;
	logic signed [15:0] activation;
	modport source (output valid, output grad_out, output activation, input ready);
	modport sink (input valid, input grad_out, input activation, output ready);
endinterface

interface rmsnb_res_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] grad_in;
	logic               last_of_row;
	logic               saturated;
	modport source (output valid, output grad_in, output last_of_row, output saturated,
		input ready);
	modport sink (input valid, input grad_in, input last_of_row, input saturated,
		output ready);
endinterface

@@ hdl/rmsnb_front.sv @@
// front end: takes pairs, writes the row buffer, accumulates sums, queues the row
// depends on rmsnb_pkg and rmsnb_pair_if
module rmsnb_front import rmsnb_pkg::*; #(
	parameter int MAX_ROW = MAX_ROW_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	rmsnb_pair_if.sink        pair,
	input  logic [LEN_W-1:0]  row_length,
	input  logic              release_row,
	output logic              wr_en,
	output logic [((MAX_ROW > 1) ? $clog2(MAX_ROW) : 1)-1:0] wr_addr,
	output logic [DATA_W-1:0] wr_grad,
	output logic [DATA_W-1:0] wr_act,
	output row_job_t          job,
	output logic              job_valid,
	input  logic              job_ready
);

	localparam int ADDR_W = (MAX_ROW > 1) ? $clog2(MAX_ROW) : 1;

	logic [LEN_W-1:0]        cnt_q;
	logic [SUM_W-1:0]        sq_q;
	logic signed [DOT_W-1:0] dot_q;
	logic                    hold_q;
	logic                    job_valid_q;
	row_job_t                job_q;

	logic [LEN_W-1:0]        len_c;
	logic [LEN_W-1:0]        cnt_inc;
	logic                    accept;
	logic                    row_end;
	logic signed [31:0]      sq_p;
	logic signed [31:0]      dp_p;
	logic [SUM_W-1:0]        sq_next;
	logic signed [DOT_W-1:0] dot_next;

	// clamp the row length into 1..MAX_ROW
	always_comb begin
		if (row_length == '0) begin
			len_c = LEN_W'(1);
		end else if (row_length > LEN_W'(MAX_ROW)) begin
			len_c = LEN_W'(MAX_ROW);
		end else begin
			len_c = row_length;
		end
	end

	assign pair.ready = !hold_q;
	assign accept     = pair.valid && !hold_q;
	assign cnt_inc    = cnt_q + LEN_W'(1);
	assign row_end    = cnt_inc >= len_c;

	// square and product of this transfer
	assign sq_p     = pair.activation * pair.activation;
	assign dp_p     = pair.grad_out * pair.activation;
	assign sq_next  = sq_q + {{(SUM_W-32){1'b0}}, sq_p};
	assign dot_next = dot_q + {{(DOT_W-32){dp_p[31]}}, dp_p};

	// buffer write
	assign wr_en   = accept;
	assign wr_addr = cnt_q[ADDR_W-1:0];
	assign wr_grad = pair.grad_out;
	assign wr_act  = pair.activation;

	assign job       = job_q;
	assign job_valid = job_valid_q;

	// accumulators and row hold; hold drops when the emitter has drained the row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			sq_q        <= '0;
			dot_q       <= '0;
			hold_q      <= 1'b0;
			job_valid_q <= 1'b0;
		end else begin
			if (job_valid_q && job_ready) begin
				job_valid_q <= 1'b0;
			end
			if (release_row) begin
				hold_q <= 1'b0;
			end
			if (accept) begin
				if (row_end) begin
					cnt_q       <= '0;
					sq_q        <= '0;
					dot_q       <= '0;
					hold_q      <= 1'b1;
					job_valid_q <= 1'b1;
				end else begin
					cnt_q <= cnt_inc;
					sq_q  <= sq_next;
					dot_q <= dot_next;
				end
			end
		end
	end

	// queued row descriptor
	always_ff @(posedge clk) begin
		if (accept && row_end) begin
			job_q.len <= len_c;
			job_q.n   <= cnt_inc;
			job_q.sq  <= sq_next;
			job_q.dot <= dot_next;
		end
	end

endmodule

@@ hdl/rmsnb_coef.sv @@
// coefficient unit: shared restoring divider, bit-pair square root, shift-add multiplier
// depends on rmsnb_pkg
module rmsnb_coef import rmsnb_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [EPS_W-1:0] epsilon,
	input  row_job_t         job,
	input  logic             job_valid,
	output logic             job_ready,
	output row_coef_t        res,
	output logic             res_valid,
	input  logic             res_ready
);

	coef_state_t state_q, state_d;
	logic [STEP_W-1:0] step_q;

	row_job_t                 job_q;
	logic [MS_W-1:0]          ms_q;
	logic [ROWDEN_W-1:0]      den_row_q;
	logic [DIV_W-1:0]         num_q;
	logic [DEN_W-1:0]         den_q;
	logic [DEN_W-1:0]         rem_q;
	logic [ROOT_W-1:0]        v_q;
	logic [ROOT_W-1:0]        r_q;
	logic [ROOT_W-1:0]        b_q;
	logic [INV_W-1:0]         inv_q;
	logic [PROD_W-1:0]        acc_q;
	logic [PROD_W-1:0]        mc_q;
	logic [INV_W-1:0]         mp_q;
	logic signed [COEF_W-1:0] coef_q;

	logic [DEN_W:0]    rem_sh;
	logic              div_ge;
	logic [DEN_W-1:0]  rem_nx;
	logic [DIV_W-1:0]  num_nx;
	logic [ROOT_W-1:0] rb;
	logic              root_ge;
	logic [MS_W:0]     ms_sum;
	logic [MS_W-1:0]   ms_c;
	logic [SUM_W-1:0]  dot_mag;
	logic [DIV_W-1:0]  gm_num;
	logic [PROD_W-24:0] cm_full;
	logic              p_ovf;
	logic [CM_W-1:0]   cm;
	logic              step0;

	// state register and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= (state_d != state_q) ? '0 : step_q + STEP_W'(1);
		end
	end

	// next state and handshakes
	always_comb begin
		state_d   = state_q;
		job_ready = 1'b0;
		res_valid = 1'b0;
		case (state_q)
			CS_IDLE: begin
				job_ready = 1'b1;
				if (job_valid) state_d = CS_MS;
			end
			CS_MS: begin
				if (step_q == STEP_W'(DIV_STEPS)) state_d = CS_Q;
			end
			CS_Q: begin
				if (step_q == STEP_W'(DIV_STEPS)) state_d = CS_ROOT;
			end
			CS_ROOT: begin
				if (step_q == STEP_W'(ROOT_STEPS)) state_d = CS_GM;
			end
			CS_GM: begin
				if (step_q == STEP_W'(DIV_STEPS)) state_d = CS_MUL;
			end
			CS_MUL: begin
				if (step_q == STEP_W'(MUL_STEPS)) state_d = CS_FIN;
			end
			CS_FIN: begin
				state_d = CS_OUT;
			end
			CS_OUT: begin
				res_valid = 1'b1;
				if (res_ready) state_d = CS_IDLE;
			end
			default: begin
				state_d = CS_IDLE;
			end
		endcase
	end

	// one divider step: shift in a numerator bit, subtract when it fits
	assign rem_sh = {rem_q, num_q[DIV_W-1]};
	assign div_ge = rem_sh >= {1'b0, den_q};
	assign rem_nx = div_ge ? DEN_W'(rem_sh - {1'b0, den_q}) : rem_sh[DEN_W-1:0];
	assign num_nx = {num_q[DIV_W-2:0], div_ge};

	// one square root step
	assign rb      = r_q + b_q;
	assign root_ge = v_q >= rb;

	// mean square plus epsilon, zero taken as one lsb
	assign ms_sum = (MS_W+1)'(num_q[MS_W-1:0]) + (MS_W+1)'(epsilon);
	assign ms_c   = (ms_sum[MS_W-1:0] == '0) ? MS_W'(1) : ms_sum[MS_W-1:0];

	// rounded numerator for dot / (len * ms)
	assign dot_mag = job_q.dot[DOT_W-1] ? SUM_W'(-job_q.dot) : SUM_W'(job_q.dot);
	assign gm_num  = DIV_W'({dot_mag, 25'b0}) + DIV_W'(den_row_q);

	// rounded coefficient magnitude, clipped if the product passes 64 bits or COEF_LIMIT
	assign cm_full = (PROD_W-23)'(acc_q[PROD_W-1:24]) + (PROD_W-23)'(acc_q[23]);
	assign p_ovf   = |acc_q[PROD_W-1:DIV_W];
	assign cm      = (p_ovf || cm_full > (PROD_W-23)'(COEF_LIMIT)) ? COEF_LIMIT
		: cm_full[CM_W-1:0];

	assign step0 = step_q == '0;

	// datapath: step zero of each phase loads operands, later steps iterate
	always_ff @(posedge clk) begin
		case (state_q)
			CS_IDLE: begin
				if (job_valid) job_q <= job;
			end
			CS_MS: begin
				if (step0) begin
					num_q <= DIV_W'({job_q.sq, 1'b0}) + DIV_W'(job_q.len);
					den_q <= DEN_W'({job_q.len, 1'b0});
					rem_q <= '0;
				end else begin
					num_q <= num_nx;
					rem_q <= rem_nx;
				end
			end
			CS_Q: begin
				if (step0) begin
					ms_q  <= ms_c;
					num_q <= Q_NUM;
					den_q <= DEN_W'(ms_c);
					rem_q <= '0;
				end else begin
					num_q <= num_nx;
					rem_q <= rem_nx;
				end
			end
			CS_ROOT: begin
				den_row_q <= job_q.len * ms_q;
				if (step0) begin
					v_q <= num_q;
					r_q <= '0;
					b_q <= ROOT_B0;
				end else begin
					if (root_ge) begin
						v_q <= v_q - rb;
						r_q <= (r_q >> 1) + b_q;
					end else begin
						r_q <= r_q >> 1;
					end
					b_q <= b_q >> 2;
				end
			end
			CS_GM: begin
				if (step0) begin
					inv_q <= INV_W'((r_q + ROOT_W'(1)) >> 1);
					num_q <= gm_num;
					den_q <= DEN_W'({den_row_q, 1'b0});
					rem_q <= '0;
				end else begin
					num_q <= num_nx;
					rem_q <= rem_nx;
				end
			end
			CS_MUL: begin
				if (step0) begin
					mc_q  <= PROD_W'(num_q[GM_W-1:0]);
					mp_q  <= inv_q;
					acc_q <= '0;
				end else begin
					if (mp_q[0]) acc_q <= acc_q + mc_q;
					mc_q <= mc_q << 1;
					mp_q <= mp_q >> 1;
				end
			end
			CS_FIN: begin
				coef_q <= job_q.dot[DOT_W-1] ? -$signed(COEF_W'(cm)) : $signed(COEF_W'(cm));
			end
			default: begin
			end
		endcase
	end

	assign res.n    = job_q.n;
	assign res.inv  = inv_q;
	assign res.coef = coef_q;

endmodule

@@ hdl/rmsnb_back.sv @@
// back end: row buffer and four-stage emitter of grad*inv - x*coef
// depends on rmsnb_pkg and rmsnb_res_if
module rmsnb_back import rmsnb_pkg::*; #(
	parameter int MAX_ROW = MAX_ROW_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [((MAX_ROW > 1) ? $clog2(MAX_ROW) : 1)-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_grad,
	input  logic [DATA_W-1:0] wr_act,
	input  row_coef_t         coef_in,
	input  logic              coef_valid,
	output logic              coef_ready,
	output logic              row_done,
	rmsnb_res_if.source       result
);

	localparam int ADDR_W = (MAX_ROW > 1) ? $clog2(MAX_ROW) : 1;
	localparam int T_W    = 66;
	localparam int MAG_W  = T_W - 18;

	logic [DATA_W-1:0] gmem [MAX_ROW];
	logic [DATA_W-1:0] xmem [MAX_ROW];

	logic                     active_q;
	logic [LEN_W-1:0]         idx_q;
	logic [LEN_W-1:0]         n_q;
	logic [INV_W-1:0]         inv_q;
	logic signed [COEF_W-1:0] coef_q;

	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic last_s1, last_s2, last_s3, last_s4;
	logic signed [DATA_W-1:0] dy_s1, x_s1;
	logic signed [47:0]       pinv_s2;
	logic signed [40:0]       plo_s2, phi_s2;
	logic signed [T_W-1:0]    t_s3;
	logic signed [DATA_W-1:0] grad_s4;
	logic                     sat_s4;

	logic             busy, adv, issue, last_issue, start;
	logic             neg;
	logic [T_W-1:0]   mag;
	logic [MAG_W-1:0] mag_r;
	logic             sat_c;
	logic [DATA_W-1:0] mag16;

	assign busy       = active_q | vld_s1 | vld_s2 | vld_s3 | vld_s4;
	assign coef_ready = !busy;
	assign start      = coef_valid && !busy;
	assign adv        = !vld_s4 || result.ready;
	assign issue      = active_q && adv;
	assign last_issue = (idx_q + LEN_W'(1)) == n_q;

	// row buffer, read data registered into stage one
	always_ff @(posedge clk) begin
		if (wr_en) begin
			gmem[wr_addr] <= wr_grad;
			xmem[wr_addr] <= wr_act;
		end
		if (issue) begin
			dy_s1 <= $signed(gmem[idx_q[ADDR_W-1:0]]);
			x_s1  <= $signed(xmem[idx_q[ADDR_W-1:0]]);
		end
	end

	// issue counter and stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			idx_q    <= '0;
			vld_s1   <= 1'b0;
			vld_s2   <= 1'b0;
			vld_s3   <= 1'b0;
			vld_s4   <= 1'b0;
		end else begin
			if (start) begin
				active_q <= 1'b1;
				idx_q    <= '0;
			end else if (issue) begin
				idx_q <= idx_q + LEN_W'(1);
				if (last_issue) active_q <= 1'b0;
			end
			if (adv) begin
				vld_s1 <= issue;
				vld_s2 <= vld_s1;
				vld_s3 <= vld_s2;
				vld_s4 <= vld_s3;
			end
		end
	end

	// row scale factors
	always_ff @(posedge clk) begin
		if (start) begin
			n_q    <= coef_in.n;
			inv_q  <= coef_in.inv;
			coef_q <= coef_in.coef;
		end
	end

	// round to nearest, ties away from zero, then saturate
	always_comb begin
		neg   = t_s3[T_W-1];
		mag   = neg ? T_W'(-t_s3) : T_W'(t_s3);
		mag_r = MAG_W'((mag + T_W'(1 << 17)) >> 18);
		sat_c = 1'b0;
		mag16 = mag_r[DATA_W-1:0];
		if (!neg && mag_r > MAG_W'(32767)) begin
			mag16 = 16'h7FFF;
			sat_c = 1'b1;
		end
		if (neg && mag_r > MAG_W'(32768)) begin
			mag16 = 16'h8000;
			sat_c = 1'b1;
		end
	end

	// product, difference and output stages
	always_ff @(posedge clk) begin
		if (adv) begin
			last_s1 <= last_issue;
			pinv_s2 <= dy_s1 * $signed({1'b0, inv_q});
			plo_s2  <= x_s1 * $signed({1'b0, coef_q[23:0]});
			phi_s2  <= x_s1 * $signed(coef_q[COEF_W-1:24]);
			last_s2 <= last_s1;
			t_s3    <= T_W'(pinv_s2) - ((T_W'(phi_s2) <<< 24) + T_W'(plo_s2));
			last_s3 <= last_s2;
			grad_s4 <= neg ? $signed(-mag16) : $signed(mag16);
			sat_s4  <= sat_c;
			last_s4 <= last_s3;
		end
	end

	assign result.valid       = vld_s4;
	assign result.grad_in     = grad_s4;
	assign result.last_of_row = last_s4;
	assign result.saturated   = sat_s4;
	assign row_done           = vld_s4 && result.ready && last_s4;

endmodule

@@ hdl/rms_norm_backward_row.sv @@
// channel    | dir | payload                               | transfer when
// pair       | in  | grad_out, activation (Q3.12)          | valid & ready
// result     | out | grad_in (Q3.12), last_of_row, saturated| valid & ready
// wr_*       | in  | wr_index, wr_data                     | wr_en
//
// A row of L pairs loads at one pair per cycle. The coefficient unit then runs
// three 64-step divisions, a 32-step square root and a 31-step multiply, after
// which results leave at one per cycle while result.ready is high, behind a 4-stage pipeline.
// pair.ready is low from the last pair of a row until its last result transfers.
// Reset is asynchronous; no clearing pass, the row buffer needs none.
// Depends on rmsnb_pkg, rmsnb_if, rmsnb_front, rmsnb_coef, rmsnb_back.
`include "rms_norm_backward_row_macros.svh"

module rms_norm_backward_row import rmsnb_pkg::*; #(
	parameter int MAX_ROW = MAX_ROW_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	rmsnb_pair_if.sink           pair,
	rmsnb_res_if.source          result,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [EPS_W-1:0]     wr_data
);

	localparam int ADDR_W = (MAX_ROW > 1) ? $clog2(MAX_ROW) : 1;

	logic [LEN_W-1:0] row_length_q;
	logic [EPS_W-1:0] epsilon_q;

	logic              mem_we;
	logic [ADDR_W-1:0] mem_addr;
	logic [DATA_W-1:0] mem_grad, mem_act;
	row_job_t          job;
	logic              job_vld, job_rdy;
	row_coef_t         coef;
	logic              coef_vld, coef_rdy;
	logic              row_done;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_length_q <= LEN_W'(ROW_LEN_RST);
			epsilon_q    <= EPS_W'(EPS_RST);
		end else if (wr_en) begin
			if (wr_index == REG_ROW_LENGTH) row_length_q <= wr_data[LEN_W-1:0];
			if (wr_index == REG_EPSILON) epsilon_q <= wr_data;
		end
	end

	rmsnb_front #(.MAX_ROW(MAX_ROW)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.pair       (pair),
		.row_length (row_length_q),
		.release_row(row_done),
		.wr_en      (mem_we),
		.wr_addr    (mem_addr),
		.wr_grad    (mem_grad),
		.wr_act     (mem_act),
		.job        (job),
		.job_valid  (job_vld),
		.job_ready  (job_rdy)
	);

	rmsnb_coef u_coef (
		.clk      (clk),
		.arst_n   (arst_n),
		.epsilon  (epsilon_q),
		.job      (job),
		.job_valid(job_vld),
		.job_ready(job_rdy),
		.res      (coef),
		.res_valid(coef_vld),
		.res_ready(coef_rdy)
	);

	rmsnb_back #(.MAX_ROW(MAX_ROW)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (mem_we),
		.wr_addr   (mem_addr),
		.wr_grad   (mem_grad),
		.wr_act    (mem_act),
		.coef_in   (coef),
		.coef_valid(coef_vld),
		.coef_ready(coef_rdy),
		.row_done  (row_done),
		.result    (result)
	);

	// the row buffer is never refilled while its row is still being emitted
	`RMSNB_ASSERT_IMPL(a_no_load_while_emit, result.valid, !pair.ready, "pair taken during emit")
	// the emitter is drained once the last result of a row transfers
	`RMSNB_ASSERT_NEXT(a_drain_after_last, result.valid && result.ready && result.last_of_row, !result.valid, "result after row end")
	// a new coefficient set only starts an idle emitter
	`RMSNB_ASSERT_IMPL(a_start_when_idle, coef_vld && coef_rdy, !result.valid, "emitter busy at start")

endmodule
